@@ design/pist_pkg.sv @@
// shared constants and types for the point-in-shape tester
`timescale 1ns / 1ps
package pist_pkg;

  localparam int MAX_VERTICES = 256;
  localparam int ADDR_W       = $clog2(MAX_VERTICES);
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
  localparam int COORD_W      = 15;
  localparam int MUL_W        = 18;
  localparam int PROD_W       = 2 * MUL_W;
  localparam int ACC_W        = 64;

  typedef enum logic [1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_APPEND = 2'd1,
    MODE_POINT  = 2'd2,
    MODE_RECT   = 2'd3
  } mode_t;

  localparam logic [1:0] KIND_POLYGON = 2'd0;
  localparam logic [1:0] KIND_RECT    = 2'd1;
  localparam logic [1:0] KIND_ELLIPSE = 2'd2;

  localparam logic [2:0] REG_SHAPE_KIND = 3'd0;
  localparam logic [2:0] REG_FIRST_X    = 3'd1;
  localparam logic [2:0] REG_FIRST_Y    = 3'd2;
  localparam logic [2:0] REG_SECOND_X   = 3'd3;
  localparam logic [2:0] REG_SECOND_Y   = 3'd4;

endpackage

@@ design/point_in_shape_test_core.sv @@
// point-in-shape tester: sequencer around one shared multiplier and a vertex memory
//
//  channel   dir  handshake                 payload
//  s_*       in   s_tvalid / s_tready       s_tdata  64 bits
//  m_*       out  m_tvalid / m_tready       m_tdata  16 bits
//  cfg_*     in   cfg_valid / cfg_ready     cfg_index, cfg_data
//
// clear and append go straight to the result; a rectangle shape compares each corner directly;
// ellipse takes 12 passes through the shared multiplier per corner;
// polygon: one memory read per edge, plus a multiply and compare step when the edge straddles the ray;
// a rectangle query runs the corner test four times
// synchronous reset clears the vertex count, the shape registers and the output, no memory sweep
// s_tready is low while an item is in work; a held result stalls only the final step
`timescale 1ns / 1ps
module point_in_shape_test_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // mode[1:0], point_x, point_y, far_x, far_y (15 each), zero fill
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // inside_res, stored_vertices[8:0], status, zero fill
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [14:0] cfg_data
);

  localparam int AW = pist_pkg::ADDR_W;
  localparam int CW = pist_pkg::CNT_W;
  localparam int W  = pist_pkg::COORD_W;
  localparam int MW = pist_pkg::MUL_W;
  localparam int PW = pist_pkg::PROD_W;
  localparam int XW = pist_pkg::ACC_W;

  typedef enum logic [3:0] {
    ST_IDLE, ST_POINT, ST_PREV, ST_RD, ST_CHK, ST_MUL2, ST_CMP,
    ST_ELL, ST_ELLF, ST_NEXT, ST_DONE
  } state_t;

  state_t state;

  logic [1:0]          shape_kind;
  logic signed [W-1:0] first_x, first_y, second_x, second_y;

  logic [2*W-1:0]      mem [pist_pkg::MAX_VERTICES];
  logic [2*W-1:0]      rdata;
  logic [AW-1:0]       rd_addr;
  logic                we;

  logic [CW-1:0]       total;
  pist_pkg::mode_t     mode;
  logic signed [W-1:0] px, py, fx, fy;
  logic [1:0]          corner;
  logic                allin, hit, parity, status;
  logic [AW-1:0]       idx;
  logic signed [W-1:0] prev_x, prev_y, cur_x, cur_y;
  logic signed [16:0]  d, a;
  logic signed [PW-1:0] prod, nn;
  logic                pos;
  logic [3:0]          step;
  logic [29:0]         u, v, w;
  logic signed [XW-1:0] acc;

  logic signed [MW-1:0] ma, mb;
  logic signed [W-1:0]  qx, qy;
  logic signed [W:0]    dx, dy, rxs, rys;
  logic [W:0]           dxm, dym, rxm, rym;
  logic signed [17:0]   kp1, kk;
  logic [W:0]           dp;
  logic                 rect_in, straddle, last_edge;
  logic signed [XW-1:0] pext;

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;

  assign qx  = corner[0] ? fx : px;
  assign qy  = corner[1] ? fy : py;
  assign dx  = (W+1)'(qx) - (W+1)'(first_x);
  assign dy  = (W+1)'(qy) - (W+1)'(first_y);
  assign rxs = (W+1)'(second_x);
  assign rys = (W+1)'(second_y);
  assign dxm = dx[W] ? (W+1)'(-dx) : (W+1)'(dx);
  assign dym = dy[W] ? (W+1)'(-dy) : (W+1)'(dy);
  assign rxm = rxs[W] ? (W+1)'(-rxs) : (W+1)'(rxs);
  assign rym = rys[W] ? (W+1)'(-rys) : (W+1)'(rys);

  assign rect_in = (qx >= first_x) && (qx < second_x) && (qy >= first_y) && (qy < second_y);

  assign straddle  = (cur_y > qy) != (prev_y > qy);
  assign last_edge = (CW'(idx) == total - CW'(1));
  assign kp1       = 18'(a) + 18'sd1;
  assign kk        = (kp1 > 0) ? kp1 : 18'(a);
  assign dp        = d[16] ? (W+1)'(-d) : (W+1)'(d);
  assign pext      = XW'(prod);

  always_comb begin
    ma = '0;
    mb = '0;
    case (state)
      ST_CHK: begin
        ma = MW'((W+1)'(prev_x) - (W+1)'(signed'(rdata[W-1:0])));
        mb = MW'((W+1)'(qy) - (W+1)'(signed'(rdata[2*W-1:W])));
      end
      ST_MUL2: begin
        ma = MW'(kk);
        mb = MW'({1'b0, dp});
      end
      ST_ELL: begin
        case (step)
          4'd0:  begin ma = MW'({1'b0, dxm}); mb = MW'({1'b0, rym}); end
          4'd1:  begin ma = MW'({1'b0, dym}); mb = MW'({1'b0, rxm}); end
          4'd2:  begin ma = MW'({1'b0, rxm}); mb = MW'({1'b0, rym}); end
          4'd3:  begin ma = MW'(u[29:15]); mb = MW'(u[29:15]); end
          4'd4:  begin ma = MW'(u[29:15]); mb = MW'(u[14:0]); end
          4'd5:  begin ma = MW'(u[14:0]);  mb = MW'(u[14:0]); end
          4'd6:  begin ma = MW'(v[29:15]); mb = MW'(v[29:15]); end
          4'd7:  begin ma = MW'(v[29:15]); mb = MW'(v[14:0]); end
          4'd8:  begin ma = MW'(v[14:0]);  mb = MW'(v[14:0]); end
          4'd9:  begin ma = MW'(w[29:15]); mb = MW'(w[29:15]); end
          4'd10: begin ma = MW'(w[29:15]); mb = MW'(w[14:0]); end
          4'd11: begin ma = MW'(w[14:0]);  mb = MW'(w[14:0]); end
          default: begin ma = '0; mb = '0; end
        endcase
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  always_comb begin
    rd_addr = idx;
    if (state == ST_POINT) begin
      rd_addr = AW'(total - CW'(1));
    end
  end

  assign we = s_tvalid && s_tready && (pist_pkg::mode_t'(s_tdata[1:0]) == pist_pkg::MODE_APPEND)
              && (total < CW'(pist_pkg::MAX_VERTICES));

  always_ff @(posedge clk) begin
    if (we) begin
      mem[total[AW-1:0]] <= s_tdata[2*W+1:2];
    end
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    prod <= ma * mb;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shape_kind <= pist_pkg::KIND_POLYGON;
      first_x    <= '0;
      first_y    <= '0;
      second_x   <= '0;
      second_y   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pist_pkg::REG_SHAPE_KIND: shape_kind <= cfg_data[1:0];
        pist_pkg::REG_FIRST_X:    first_x    <= cfg_data;
        pist_pkg::REG_FIRST_Y:    first_y    <= cfg_data;
        pist_pkg::REG_SECOND_X:   second_x   <= cfg_data;
        pist_pkg::REG_SECOND_Y:   second_y   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      total    <= '0;
      m_tvalid <= 1'b0;
      m_tdata  <= '0;
    end else begin
      if (m_tvalid && m_tready && state != ST_DONE) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            mode   <= pist_pkg::mode_t'(s_tdata[1:0]);
            px     <= s_tdata[16:2];
            py     <= s_tdata[31:17];
            fx     <= s_tdata[46:32];
            fy     <= s_tdata[61:47];
            corner <= 2'd0;
            case (pist_pkg::mode_t'(s_tdata[1:0]))
              pist_pkg::MODE_CLEAR: begin
                total  <= '0;
                allin  <= 1'b0;
                status <= 1'b0;
                state  <= ST_DONE;
              end
              pist_pkg::MODE_APPEND: begin
                allin <= 1'b0;
                if (total < CW'(pist_pkg::MAX_VERTICES)) begin
                  total  <= total + CW'(1);
                  status <= 1'b0;
                end else begin
                  status <= 1'b1;
                end
                state <= ST_DONE;
              end
              default: begin
                allin  <= 1'b1;
                status <= 1'b0;
                state  <= ST_POINT;
              end
            endcase
          end
        end
        ST_POINT: begin
          hit    <= (shape_kind == pist_pkg::KIND_RECT) && rect_in;
          parity <= 1'b0;
          step   <= '0;
          idx    <= '0;
          case (shape_kind)
            pist_pkg::KIND_RECT: begin
              state <= ST_NEXT;
            end
            pist_pkg::KIND_ELLIPSE: begin
              state <= (second_x == '0 || second_y == '0) ? ST_NEXT : ST_ELL;
            end
            pist_pkg::KIND_POLYGON: begin
              state <= (total < CW'(3)) ? ST_NEXT : ST_PREV;
            end
            default: state <= ST_NEXT;
          endcase
        end
        ST_PREV: begin
          prev_x <= rdata[W-1:0];
          prev_y <= rdata[2*W-1:W];
          state  <= ST_RD;
        end
        ST_RD: begin
          state <= ST_CHK;
        end
        ST_CHK: begin
          cur_x <= rdata[W-1:0];
          cur_y <= rdata[2*W-1:W];
          d     <= 17'(prev_y) - 17'(signed'(rdata[2*W-1:W]));
          a     <= 17'(qx) - 17'(signed'(rdata[W-1:0]));
          if ((signed'(rdata[2*W-1:W]) > qy) != (prev_y > qy)) begin
            state <= ST_MUL2;
          end else begin
            prev_x <= rdata[W-1:0];
            prev_y <= rdata[2*W-1:W];
            if (CW'(idx) == total - CW'(1)) begin
              hit   <= parity;
              state <= ST_NEXT;
            end else begin
              idx   <= idx + AW'(1);
              state <= ST_RD;
            end
          end
        end
        ST_MUL2: begin
          nn    <= d[16] ? -prod : prod;
          pos   <= (kp1 > 0);
          state <= ST_CMP;
        end
        ST_CMP: begin
          prev_x <= cur_x;
          prev_y <= cur_y;
          if (straddle && (pos ? (nn >= prod) : (nn > prod))) begin
            parity <= ~parity;
          end
          if (last_edge) begin
            hit   <= parity ^ (pos ? (nn >= prod) : (nn > prod));
            state <= ST_NEXT;
          end else begin
            idx   <= idx + AW'(1);
            state <= ST_RD;
          end
        end
        ST_ELL: begin
          step <= step + 4'd1;
          case (step)
            4'd1:  u <= prod[29:0];
            4'd2:  v <= prod[29:0];
            4'd3:  begin w <= prod[29:0]; acc <= '0; end
            4'd4:  acc <= acc + (pext <<< 30);
            4'd5:  acc <= acc + (pext <<< 16);
            4'd6:  acc <= acc + pext;
            4'd7:  acc <= acc + (pext <<< 30);
            4'd8:  acc <= acc + (pext <<< 16);
            4'd9:  acc <= acc + pext;
            4'd10: acc <= acc - (pext <<< 30);
            4'd11: acc <= acc - (pext <<< 16);
            4'd12: begin
              acc   <= acc - pext;
              state <= ST_ELLF;
            end
            default: ;
          endcase
        end
        ST_ELLF: begin
          hit   <= (acc <= 0);
          state <= ST_NEXT;
        end
        ST_NEXT: begin
          allin <= allin & hit;
          if (mode == pist_pkg::MODE_RECT && corner != 2'd3) begin
            corner <= corner + 2'd1;
            state  <= ST_POINT;
          end else begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {5'd0, status, 9'(total), allin};
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    total <= CW'(pist_pkg::MAX_VERTICES))
    else $error("vertex count beyond store size");

  a_drop_only_full: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[10] |-> m_tdata[9:1] == 9'(pist_pkg::MAX_VERTICES))
    else $error("append dropped with room left");

  a_flag_excl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[0] && m_tdata[10]))
    else $error("inside and drop flag together");

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> state != ST_IDLE)
    else $error("item taken but sequencer idle");

endmodule

@@ tb/sv/point_in_shape_test_core_tb.sv @@
// testbench for the point-in-shape tester: queued stimulus, clocked driver and monitor
`timescale 1ns / 1ps
module point_in_shape_test_core_tb;
  import pist_pkg::*;

  typedef struct packed {
    logic [1:0]  mode;
    logic [14:0] px;
    logic [14:0] py;
    logic [14:0] fx;
    logic [14:0] fy;
  } shape_item_t;

  typedef struct packed {
    logic       in_flag;
    logic [8:0] count;
    logic       status;
  } shape_answer_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [14:0] cfg_data = '0;

  point_in_shape_test_core i_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // own copy of the shape state
  logic [1:0]   kind_m;
  int           fxr, fyr, sxr, syr;
  logic [29:0]  verts [MAX_VERTICES];
  int           nverts;

  shape_item_t   pending_words[$];
  shape_answer_t expected_answers[$];
  int            errors = 0;
  int            answers_seen = 0;
  int            inside_seen = 0;
  int            drops_seen = 0;
  int            burst_left = 0;
  int            gap_left = 0;
  bit            hold_sender = 1'b0;
  longint        cycles = 0;

  function automatic int sx(logic [14:0] v);
    return int'(signed'(v));
  endfunction

  function automatic bit polygon_has(int x, int y);
    int j;
    int hits;
    longint xi, yi, xj, yj, cr;
    hits = 0;
    if (nverts < 3) return 1'b0;
    j = nverts - 1;
    for (int i = 0; i < nverts; i++) begin
      xi = sx(verts[i][14:0]);
      yi = sx(verts[i][29:15]);
      xj = sx(verts[j][14:0]);
      yj = sx(verts[j][29:15]);
      if ((yi > y) != (yj > y)) begin
        cr = (xj - xi) * (y - yi) / (yj - yi) + xi;
        if (x < cr) hits++;
      end
      j = i;
    end
    return hits[0];
  endfunction

  function automatic bit shape_has(int x, int y);
    longint rx2, ry2, dx, dy;
    case (kind_m)
      KIND_RECT: return x >= fxr && x < sxr && y >= fyr && y < syr;
      KIND_ELLIPSE: begin
        if (sxr == 0 || syr == 0) return 1'b0;
        rx2 = longint'(sxr) * sxr;
        ry2 = longint'(syr) * syr;
        dx = x - fxr;
        dy = y - fyr;
        return dx * dx * ry2 + dy * dy * rx2 <= rx2 * ry2;
      end
      KIND_POLYGON: return polygon_has(x, y);
      default: return 1'b0;
    endcase
  endfunction

  function automatic shape_answer_t predict_answer(shape_item_t it);
    shape_answer_t a;
    a = '0;
    case (mode_t'(it.mode))
      MODE_CLEAR: nverts = 0;
      MODE_APPEND: begin
        if (nverts < MAX_VERTICES) begin
          verts[nverts] = {it.py, it.px};
          nverts++;
        end else begin
          a.status = 1'b1;
        end
      end
      MODE_POINT: a.in_flag = shape_has(sx(it.px), sx(it.py));
      default: a.in_flag = shape_has(sx(it.px), sx(it.py)) && shape_has(sx(it.fx), sx(it.py))
                           && shape_has(sx(it.px), sx(it.fy)) && shape_has(sx(it.fx), sx(it.fy));
    endcase
    a.count = nverts[8:0];
    return a;
  endfunction

  // driver
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst) begin
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0 || hold_sender || pending_words.size() == 0) begin
          s_tvalid <= 1'b0;
          if (gap_left > 0) gap_left <= gap_left - 1;
        end else begin
          shape_item_t it;
          it = pending_words.pop_front();
          expected_answers = {expected_answers, predict_answer(it)};
          s_tdata <= {4'd0, it.fy, it.fx, it.py, it.px, it.mode};
          s_tvalid <= 1'b1;
          if (burst_left <= 0) begin
            burst_left <= $urandom_range(1, 12);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst) begin
      m_tready <= (cycles % 400 < 150) ? 1'b1 : ($urandom_range(0, 2) != 0);
      if (m_tvalid && m_tready) begin
        shape_answer_t got, exp;
        got = {m_tdata[0], m_tdata[9:1], m_tdata[10]};
        answers_seen <= answers_seen + 1;
        if (expected_answers.size() == 0) begin
          $display("%0t unexpected word: expected none, actual %h", $time, got);
          errors <= errors + 1;
        end else begin
          exp = expected_answers.pop_front();
          if (got.in_flag) inside_seen <= inside_seen + 1;
          if (got.status) drops_seen <= drops_seen + 1;
          if (got.in_flag !== exp.in_flag || got.count !== exp.count
              || got.status !== exp.status) begin
            $display("%0t mismatch: expected in=%b n=%0d st=%b, actual in=%b n=%0d st=%b",
                     $time, exp.in_flag, exp.count, exp.status,
                     got.in_flag, got.count, got.status);
            errors <= errors + 1;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > 3000000) begin
      $display("point_in_shape_test_core test failed");
      $finish;
    end
  end

  task automatic add_word(logic [1:0] m, int x, int y, int fx = 0, int fy = 0);
    shape_item_t it;
    it.mode = m;
    it.px = x[14:0];
    it.py = y[14:0];
    it.fx = fx[14:0];
    it.fy = fy[14:0];
    pending_words = {pending_words, it};
  endtask

  task automatic drain();
    while (pending_words.size() != 0 || expected_answers.size() != 0 || s_tvalid)
      @(posedge clk);
    repeat (3000) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, int v);
    cfg_index <= idx;
    cfg_data <= v[14:0];
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_SHAPE_KIND: kind_m = v[1:0];
      REG_FIRST_X: fxr = sx(v[14:0]);
      REG_FIRST_Y: fyr = sx(v[14:0]);
      REG_SECOND_X: sxr = sx(v[14:0]);
      default: syr = sx(v[14:0]);
    endcase
  endtask

  task automatic set_shape(int k, int a, int b, int c, int d);
    write_reg(REG_SHAPE_KIND, k);
    write_reg(REG_FIRST_X, a);
    write_reg(REG_FIRST_Y, b);
    write_reg(REG_SECOND_X, c);
    write_reg(REG_SECOND_Y, d);
  endtask

  function automatic int rc();
    return $urandom_range(0, 32767) - 16384;
  endfunction

  function automatic int near(int r);
    return $urandom_range(0, 2 * r) - r;
  endfunction

  task automatic random_queries(int n, int r);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0)
        add_word(MODE_RECT, rc(), rc(), rc(), rc());
      else if ($urandom_range(0, 1))
        add_word(MODE_POINT, near(r), near(r));
      else
        add_word(MODE_RECT, near(r), near(r), near(r), near(r));
    end
  endtask

  initial begin
    int r;
    kind_m = KIND_POLYGON;
    fxr = 0; fyr = 0; sxr = 0; syr = 0;
    nverts = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: polygon with few vertices, then a triangle, extremes
    add_word(MODE_POINT, 0, 0);
    add_word(MODE_APPEND, -16384, -16384);
    add_word(MODE_APPEND, 16383, -16384);
    add_word(MODE_POINT, 0, 0);
    add_word(MODE_APPEND, 0, 16383);
    add_word(MODE_POINT, 0, 0);
    add_word(MODE_POINT, 16383, 16383);
    add_word(MODE_RECT, -10, -10, 10, 10);
    add_word(MODE_RECT, -16384, -16384, 16383, 16383);
    add_word(MODE_CLEAR, 0, 0);
    add_word(MODE_POINT, 0, 0);
    drain();
    set_shape(KIND_RECT, -16384, -16384, 16383, 16383);
    add_word(MODE_POINT, -16384, -16384);
    add_word(MODE_POINT, 16383, 0);
    add_word(MODE_RECT, -16384, -16384, 16382, 16382);
    drain();
    set_shape(KIND_ELLIPSE, 0, 0, -16384, 16383);
    add_word(MODE_POINT, 16384 - 1, 0);
    add_word(MODE_POINT, -16384, 0);
    add_word(MODE_POINT, 0, -16384);
    add_word(MODE_RECT, -100, -100, 100, 100);
    drain();
    set_shape(3, 0, 0, 100, 100);
    add_word(MODE_POINT, 5, 5);
    drain();
    set_shape(KIND_ELLIPSE, 10, 10, 0, 50);
    add_word(MODE_POINT, 10, 10);
    drain();

    // random phases over all kinds
    for (int ph = 0; ph < 12; ph++) begin
      r = (ph % 3 == 0) ? 16384 : $urandom_range(20, 2000);
      case (ph % 4)
        0: begin
          set_shape(KIND_POLYGON, rc(), rc(), rc(), rc());
          add_word(MODE_CLEAR, rc(), rc());
          for (int v = 0, nv = (ph == 4) ? 260 : $urandom_range(0, 12); v < nv; v++)
            add_word(MODE_APPEND, (v == 0 && ph == 0) ? 0 : near(r > 16383 ? 16383 : r),
                     near(r > 16383 ? 16383 : r), rc(), rc());
          random_queries(ph == 4 ? 30 : 90, r > 16383 ? 16383 : r);
        end
        1: begin
          set_shape(KIND_RECT, near(r / 2 + 1), near(r / 2 + 1), near(r), near(r));
          random_queries(110, r > 16383 ? 16383 : r);
        end
        2: begin
          set_shape(KIND_ELLIPSE, near(r / 4 + 1), near(r / 4 + 1), near(r > 16383 ? 16383 : r),
                    near(r > 16383 ? 16383 : r));
          random_queries(110, r > 16383 ? 16383 : r);
        end
        default: begin
          set_shape(KIND_POLYGON, rc(), rc(), rc(), rc());
          for (int v = 0; v < 6; v++) add_word(MODE_APPEND, rc(), rc());
          random_queries(60, 16383);
          add_word(MODE_CLEAR, 0, 0);
          for (int v = 0; v < 3; v++) add_word(MODE_APPEND, near(300), near(300));
          hold_sender = 1'b1;
          while (expected_answers.size() != 0 || s_tvalid) @(posedge clk);
          hold_sender = 1'b0;
          random_queries(40, 400);
        end
      endcase
      drain();
    end

    $display("covered %0d answers, %0d inside, %0d dropped appends", answers_seen,
             inside_seen, drops_seen);
    $display("shapes: polygon, rectangle, ellipse and unused kind, incl. extremes");
    if (errors == 0) begin
      $display("point_in_shape_test_core test passed");
    end else begin
      $display("point_in_shape_test_core test failed");
    end
    $finish;
  end
endmodule
